/* design/psc_pkg.sv */
package psc_pkg;

  localparam int unsigned NumCfg = 7;

  typedef enum logic [2:0] {
    REG_AC1        = 3'd0,
    REG_AC2        = 3'd1,
    REG_AC3        = 3'd2,
    REG_AC4        = 3'd3,
    REG_TEMP_PAIR  = 3'd4,
    REG_QUAD_PAIR  = 3'd5,
    REG_CURVE_PAIR = 3'd6
  } reg_index_t;

  localparam logic [31:0] C4000 = 32'd4000;
  localparam logic [31:0] C3038 = 32'd3038;
  localparam logic [31:0] CM7357 = 32'hFFFF_E343;
  localparam logic [31:0] C3791 = 32'd3791;
  localparam logic [31:0] C50000 = 32'd50000;
  localparam logic [31:0] C32768 = 32'd32768;

  // Calibration coefficients, each sign- or zero-extended to 32 bits.
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
  } cal_t;

endpackage

/* design/psc_divider.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Quotient 32 bits, 32 stages; side data travels with each item.
module psc_divider
  import psc_pkg::*;
#(
  parameter int SideWidth = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic [31:0]          in_dividend,
  input  logic [31:0]          in_divisor,
  input  logic [SideWidth-1:0] in_side,
  output logic                 out_valid,
  output logic [31:0]          out_quotient,
  output logic [SideWidth-1:0] out_side
);

  localparam int Steps = 32;

  logic                 vld  [Steps];
  logic [31:0]          rem  [Steps];
  logic [31:0]          quo  [Steps];
  logic [31:0]          dvs  [Steps];
  logic [SideWidth-1:0] side [Steps];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < Steps; s++) vld[s] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int s = 1; s < Steps; s++) vld[s] <= vld[s-1];
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [31:0] rem_in;
    logic [31:0] quo_in;
    logic [31:0] dvs_in;
    logic [32:0] trial;
    if (s == 0) begin : g_first
      assign rem_in = 32'd0;
      assign quo_in = in_dividend;
      assign dvs_in = in_divisor;
    end else begin : g_rest
      assign rem_in = rem[s-1];
      assign quo_in = quo[s-1];
      assign dvs_in = dvs[s-1];
    end
    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial = {rem_in, quo_in[31]} - {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (advance) begin
        if (!trial[32]) begin
          rem[s] <= trial[31:0];
        end else begin
          rem[s] <= {rem_in[30:0], quo_in[31]};
        end
        quo[s] <= {quo_in[30:0], ~trial[32]};
        dvs[s] <= dvs_in;
        if (s == 0) begin
          side[s] <= in_side;
        end else begin
          side[s] <= side[s-1];
        end
      end
    end
  end

  assign out_valid    = vld[Steps-1];
  assign out_quotient = quo[Steps-1];
  assign out_side     = side[Steps-1];

endmodule

/* design/pressure_sensor_compensation_top.sv */
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------
// input     | in_valid/in_ready   | raw_temperature, raw_pressure
// output    | out_valid/out_ready | temperature_tenths, pressure_pa, divide_fault
// config    | cfg_write           | cfg_index, cfg_data
// One item enters per cycle while the pipeline advances. Each item passes
// through two 32-stage bit-per-stage dividers and the multiply stages around them.
// Reset clears all valid bits and loads the factory calibration defaults.
// The whole pipeline advances only when the output register is empty or
// taken, so a stall freezes every stage and nothing is lost or repeated.
module pressure_sensor_compensation_top
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] raw_temperature,
  input  logic [15:0] raw_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] temperature_tenths,
  output logic [19:0] pressure_pa,
  output logic        divide_fault,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] r_ac1, r_ac2, r_ac3, r_ac4;
  logic [31:0] r_temp, r_quad, r_curve;
  cal_t cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ac1 <= 16'd408;
      r_ac2 <= 16'd65464;
      r_ac3 <= 16'd51153;
      r_ac4 <= 16'd32741;
      r_temp <= 32'd2146785905;
      r_quad <= 32'd405667844;
      r_curve <= 32'd3724086068;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AC1:        r_ac1 <= cfg_data[15:0];
        REG_AC2:        r_ac2 <= cfg_data[15:0];
        REG_AC3:        r_ac3 <= cfg_data[15:0];
        REG_AC4:        r_ac4 <= cfg_data[15:0];
        REG_TEMP_PAIR:  r_temp <= cfg_data;
        REG_QUAD_PAIR:  r_quad <= cfg_data;
        REG_CURVE_PAIR: r_curve <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = {{16{r_ac1[15]}}, r_ac1};
    cal.ac2 = {{16{r_ac2[15]}}, r_ac2};
    cal.ac3 = {{16{r_ac3[15]}}, r_ac3};
    cal.ac4 = {16'd0, r_ac4};
    cal.ac5 = {16'd0, r_temp[31:16]};
    cal.ac6 = {16'd0, r_temp[15:0]};
    cal.b1  = {{16{r_quad[31]}}, r_quad[31:16]};
    cal.b2  = {{16{r_quad[15]}}, r_quad[15:0]};
    cal.mc  = {{16{r_curve[31]}}, r_curve[31:16]};
    cal.md  = {{16{r_curve[15]}}, r_curve[15:0]};
  end

  // Global advance: every stage moves when the output register can take data.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic logic [31:0] asr(input logic [31:0] v, input int n);
    return 32'($signed(v) >>> n);
  endfunction

  // ---- Stage A: UT - AC6, product with AC5.
  logic        a_v;
  logic [31:0] a_prod;
  logic [15:0] a_up;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_valid;
    if (adv) begin
      a_prod <= 32'(({16'd0, raw_temperature} - cal.ac6) * cal.ac5);
      a_up   <= raw_pressure;
    end
  end

  // ---- Stage B: X1, denominator, sign handling for the signed division.
  logic        b_v;
  logic [31:0] b_x1, b_num_mag, b_den_mag;
  logic        b_neg, b_zero;
  logic [15:0] b_up;
  logic [31:0] x1_c, den_c, num_c;
  assign x1_c  = asr(a_prod, 15);
  assign den_c = x1_c + cal.md;
  assign num_c = cal.mc << 11;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
    if (adv) begin
      b_x1      <= x1_c;
      b_num_mag <= num_c[31] ? -num_c : num_c;
      b_den_mag <= den_c[31] ? -den_c : den_c;
      b_neg     <= num_c[31] ^ den_c[31];
      b_zero    <= den_c == 32'd0;
      b_up      <= a_up;
    end
  end

  localparam int SideT = 32 + 1 + 1 + 16;
  logic             dt_v;
  logic [31:0]      dt_q;
  logic [SideT-1:0] dt_side;
  psc_divider #(.SideWidth(SideT)) u_div_t (
    .clk, .rst, .advance(adv),
    .in_valid(b_v), .in_dividend(b_num_mag), .in_divisor(b_den_mag),
    .in_side({b_x1, b_neg, b_zero, b_up}),
    .out_valid(dt_v), .out_quotient(dt_q), .out_side(dt_side)
  );

  // ---- Stage C: B5, B6.
  logic        c_v, c_zero;
  logic [31:0] c_b5, c_b6;
  logic [15:0] c_up;
  logic [31:0] x2_c, b5_c;
  assign x2_c = dt_side[17] ? -dt_q : dt_q;
  assign b5_c = dt_side[SideT-1 -: 32] + x2_c;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= dt_v;
    if (adv) begin
      c_b5   <= b5_c;
      c_b6   <= b5_c - C4000;
      c_zero <= dt_side[16];
      c_up   <= dt_side[15:0];
    end
  end

  // ---- Stage D: B6 squared, AC2*B6, AC3*B6.
  logic        d_v, d_zero;
  logic [31:0] d_b5, d_sqp, d_ac2b6, d_ac3b6;
  logic [15:0] d_up;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= c_v;
    if (adv) begin
      d_b5    <= c_b5;
      d_sqp   <= 32'(c_b6 * c_b6);
      d_ac2b6 <= 32'(cal.ac2 * c_b6);
      d_ac3b6 <= 32'(cal.ac3 * c_b6);
      d_zero  <= c_zero;
      d_up    <= c_up;
    end
  end

  // ---- Stage E: B2*sq, B1*sq.
  logic        e_v, e_zero;
  logic [31:0] e_b5, e_b2sq, e_b1sq, e_x2a, e_x1b;
  logic [15:0] e_up;
  logic [31:0] sq_c;
  assign sq_c = asr(d_sqp, 12);
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= d_v;
    if (adv) begin
      e_b5   <= d_b5;
      e_b2sq <= 32'(cal.b2 * sq_c);
      e_b1sq <= 32'(cal.b1 * sq_c);
      e_x2a  <= asr(d_ac2b6, 11);
      e_x1b  <= asr(d_ac3b6, 13);
      e_zero <= d_zero;
      e_up   <= d_up;
    end
  end

  // ---- Stage F: B3 and X3 for B4.
  logic        f_v, f_zero;
  logic [31:0] f_b5, f_b3, f_x3;
  logic [15:0] f_up;
  logic [31:0] x3a_c, n3_c, x3b_c;
  assign x3a_c = asr(e_b2sq, 11) + e_x2a;
  assign n3_c  = (cal.ac1 << 2) + x3a_c + 32'd2;
  assign x3b_c = asr(e_x1b + asr(e_b1sq, 16) + 32'd2, 2);
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
    if (adv) begin
      f_b5   <= e_b5;
      // Signed divide by four, truncating toward zero.
      f_b3   <= asr(n3_c + (n3_c[31] ? 32'd3 : 32'd0), 2);
      f_x3   <= x3b_c + C32768;
      f_zero <= e_zero;
      f_up   <= e_up;
    end
  end

  // ---- Stage G: B4 product, B7 product.
  logic        g_v, g_zero;
  logic [31:0] g_b5, g_b4p, g_b7;
  always_ff @(posedge clk) begin
    if (rst) g_v <= 1'b0;
    else if (adv) g_v <= f_v;
    if (adv) begin
      g_b5   <= f_b5;
      g_b4p  <= 32'(cal.ac4 * f_x3);
      g_b7   <= 32'(({16'd0, f_up} - f_b3) * C50000);
      g_zero <= f_zero;
    end
  end

  // ---- Stage H: divider operands.
  logic        h_v, h_fault, h_big;
  logic [31:0] h_b5, h_num, h_b4;
  logic [31:0] b4_c;
  assign b4_c = g_b4p >> 15;
  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else if (adv) h_v <= g_v;
    if (adv) begin
      h_b5    <= g_b5;
      h_b4    <= b4_c;
      h_big   <= g_b7[31];
      h_num   <= g_b7[31] ? g_b7 : (g_b7 << 1);
      h_fault <= g_zero || (b4_c == 32'd0);
    end
  end

  localparam int SideP = 32 + 1 + 1;
  logic             dp_v;
  logic [31:0]      dp_q;
  logic [SideP-1:0] dp_side;
  psc_divider #(.SideWidth(SideP)) u_div_p (
    .clk, .rst, .advance(adv),
    .in_valid(h_v), .in_dividend(h_num), .in_divisor(h_b4),
    .in_side({h_b5, h_big, h_fault}),
    .out_valid(dp_v), .out_quotient(dp_q), .out_side(dp_side)
  );

  // ---- Stage I: p, p>>8 squared, -7357*p.
  logic        i_v, i_fault;
  logic [31:0] i_b5, i_p, i_sq, i_m2;
  logic [31:0] p_c, p8_c;
  assign p_c  = dp_side[1] ? (dp_q << 1) : dp_q;
  assign p8_c = asr(p_c, 8);
  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (adv) i_v <= dp_v;
    if (adv) begin
      i_b5    <= dp_side[SideP-1 -: 32];
      i_p     <= p_c;
      i_sq    <= 32'(p8_c * p8_c);
      i_m2    <= 32'(CM7357 * p_c);
      i_fault <= dp_side[0];
    end
  end

  // ---- Stage J: 3038 product.
  logic        j_v, j_fault;
  logic [31:0] j_b5, j_p, j_m1, j_x2;
  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (adv) j_v <= i_v;
    if (adv) begin
      j_b5    <= i_b5;
      j_p     <= i_p;
      j_m1    <= 32'(i_sq * C3038);
      j_x2    <= asr(i_m2, 16);
      j_fault <= i_fault;
    end
  end

  // ---- Stage K: final sums and saturation into the output register.
  logic [31:0] pf_c, t_c;
  logic signed [15:0] t_sat;
  logic [19:0] p_sat;
  assign pf_c = j_p + asr(asr(j_m1, 16) + j_x2 + C3791, 4);
  assign t_c  = asr(j_b5 + 32'd8, 4);
  always_comb begin
    if ($signed(t_c) > 32'sd32767) t_sat = 16'sh7FFF;
    else if ($signed(t_c) < -32'sd32768) t_sat = -16'sh8000;
    else t_sat = t_c[15:0];
    if (pf_c[31]) p_sat = 20'd0;
    else if (pf_c[30:20] != 11'd0) p_sat = 20'hFFFFF;
    else p_sat = pf_c[19:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= j_v;
    if (adv) begin
      temperature_tenths <= j_fault ? 16'sd0 : t_sat;
      pressure_pa        <= j_fault ? 20'd0 : p_sat;
      divide_fault       <= j_fault;
    end
  end

endmodule
